### hw/rtl/assert_macros.svh
// Assertion helpers used by jacobi_pressure_projection.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define JPP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define JPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/jpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jpp_pkg;

	localparam int GRID_W     = 128;
	localparam int GRID_H     = 128;
	localparam int CELL_COUNT = GRID_W * GRID_H;
	localparam int IDX_W      = $clog2(CELL_COUNT);
	localparam int XW         = $clog2(GRID_W);
	localparam int YW         = $clog2(GRID_H);
	localparam int ACC_W      = 36;
	localparam logic [7:0] ITER_RESET = 8'd20;

	// Item actions.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Run phases.
	localparam logic [2:0] PH_DIV  = 3'd0;
	localparam logic [2:0] PH_JAC  = 3'd1;
	localparam logic [2:0] PH_PEC  = 3'd2;
	localparam logic [2:0] PH_PER  = 3'd3;
	localparam logic [2:0] PH_PROJ = 3'd4;
	localparam logic [2:0] PH_VEC  = 3'd5;
	localparam logic [2:0] PH_VER  = 3'd6;

	// Logical stores seen by the sequencer.
	localparam logic [2:0] M_U   = 3'd0;
	localparam logic [2:0] M_V   = 3'd1;
	localparam logic [2:0] M_CUR = 3'd2;
	localparam logic [2:0] M_PRV = 3'd3;
	localparam logic [2:0] M_DIV = 3'd4;

	// Physical stores.
	localparam logic [2:0] R_U = 3'd0;
	localparam logic [2:0] R_V = 3'd1;
	localparam logic [2:0] R_A = 3'd2;
	localparam logic [2:0] R_B = 3'd3;
	localparam logic [2:0] R_D = 3'd4;

	// Neighbour offsets.
	localparam logic [2:0] OF_0  = 3'd0;
	localparam logic [2:0] OF_P1 = 3'd1;
	localparam logic [2:0] OF_M1 = 3'd2;
	localparam logic [2:0] OF_PW = 3'd3;
	localparam logic [2:0] OF_MW = 3'd4;

	typedef struct packed {
		logic [1:0]         action;
		logic [13:0]        cell_index;
		logic signed [31:0] u_in;
		logic signed [31:0] v_in;
	} item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] u_out;
		logic signed [31:0] v_out;
	} res_t;

	typedef struct packed {
		logic [2:0] mem;
		logic [2:0] off;
		logic       neg;
	} term_t;

	typedef struct packed {
		logic [2:0] n;
		logic [2:0] dst;
		logic [1:0] sh;
	} plan_t;

	typedef struct packed {
		logic       clr;
		logic       acc_en;
		logic       neg;
		logic [1:0] sh;
	} alu_ctl_t;

	// Operand count, destination and final shift of one cell update.
	function automatic plan_t plan_f(input logic [2:0] ph, input logic sub);
		plan_t p;
		p = '{n: 3'd1, dst: M_CUR, sh: 2'd0};
		case (ph)
			PH_DIV:  p = '{n: 3'd4, dst: M_DIV, sh: 2'd1};
			PH_JAC:  p = '{n: 3'd5, dst: M_CUR, sh: 2'd2};
			PH_PEC:  p = '{n: 3'd1, dst: M_CUR, sh: 2'd0};
			PH_PER:  p = '{n: 3'd1, dst: M_CUR, sh: 2'd0};
			PH_PROJ: p = '{n: 3'd4, dst: sub ? M_V : M_U, sh: 2'd1};
			PH_VEC:  p = sub ? plan_t'{n: 3'd1, dst: M_V, sh: 2'd0}
			                 : plan_t'{n: 3'd0, dst: M_U, sh: 2'd0};
			PH_VER:  p = sub ? plan_t'{n: 3'd0, dst: M_V, sh: 2'd0}
			                 : plan_t'{n: 3'd1, dst: M_U, sh: 2'd0};
			default: p = '{n: 3'd1, dst: M_CUR, sh: 2'd0};
		endcase
		return p;
	endfunction

	// Operand k of one cell update; side is set for the left or top edge.
	function automatic term_t term_f(input logic [2:0] ph, input logic sub,
			input logic side, input logic [2:0] k);
		term_t t;
		logic [2:0] xc;
		logic [2:0] yc;
		t  = '{mem: M_U, off: OF_0, neg: 1'b0};
		xc = side ? OF_P1 : OF_M1;
		yc = side ? OF_PW : OF_MW;
		case (ph)
			PH_DIV: begin
				case (k)
					3'd0:    t = '{mem: M_U, off: OF_P1, neg: 1'b0};
					3'd1:    t = '{mem: M_U, off: OF_M1, neg: 1'b1};
					3'd2:    t = '{mem: M_V, off: OF_PW, neg: 1'b0};
					default: t = '{mem: M_V, off: OF_MW, neg: 1'b1};
				endcase
			end
			PH_JAC: begin
				case (k)
					3'd0:    t = '{mem: M_PRV, off: OF_M1, neg: 1'b0};
					3'd1:    t = '{mem: M_PRV, off: OF_P1, neg: 1'b0};
					3'd2:    t = '{mem: M_PRV, off: OF_MW, neg: 1'b0};
					3'd3:    t = '{mem: M_PRV, off: OF_PW, neg: 1'b0};
					default: t = '{mem: M_DIV, off: OF_0, neg: 1'b1};
				endcase
			end
			PH_PEC:  t = '{mem: M_CUR, off: xc, neg: 1'b0};
			PH_PER:  t = '{mem: M_CUR, off: yc, neg: 1'b0};
			PH_PROJ: begin
				case (k)
					3'd0, 3'd1: t = '{mem: sub ? M_V : M_U, off: OF_0, neg: 1'b0};
					3'd2:    t = '{mem: M_CUR, off: sub ? OF_PW : OF_P1, neg: 1'b1};
					default: t = '{mem: M_CUR, off: sub ? OF_MW : OF_M1, neg: 1'b0};
				endcase
			end
			PH_VEC:  t = '{mem: M_V, off: xc, neg: 1'b0};
			PH_VER:  t = '{mem: M_U, off: yc, neg: 1'b0};
			default: t = '{mem: M_U, off: OF_0, neg: 1'b0};
		endcase
		return t;
	endfunction

	// Map a logical store onto a physical store; current and previous pressure go to store a or b.
	function automatic logic [2:0] phys_f(input logic [2:0] m, input logic cur_b);
		logic [2:0] r;
		case (m)
			M_U:     r = R_U;
			M_V:     r = R_V;
			M_CUR:   r = cur_b ? R_B : R_A;
			M_PRV:   r = cur_b ? R_A : R_B;
			default: r = R_D;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/jpp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module jpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/jpp_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module jpp_alu (
	input  wire logic                clk,
	input  wire jpp_pkg::alu_ctl_t   ctl,
	input  wire logic signed [31:0]  din,
	output logic signed [31:0]       dout
);

	localparam logic signed [jpp_pkg::ACC_W-1:0] SMAX = jpp_pkg::ACC_W'(32'h7fffffff);
	localparam logic signed [jpp_pkg::ACC_W-1:0] SMIN = -SMAX - jpp_pkg::ACC_W'(1);

	logic signed [jpp_pkg::ACC_W-1:0] acc_q;
	logic signed [jpp_pkg::ACC_W-1:0] ext;
	logic signed [jpp_pkg::ACC_W-1:0] shifted;

	assign ext = jpp_pkg::ACC_W'(din);

	// Exact running sum of the operands of one cell.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.neg ? acc_q - ext : acc_q + ext;
		end
	end

	// Floor halving or quartering as sh selects (or no shift), then saturation to 32 bits.
	always_comb begin
		shifted = acc_q >>> ctl.sh;
		if (shifted > SMAX) begin
			dout = 32'sh7fffffff;
		end else if (shifted < SMIN) begin
			dout = -32'sh7fffffff - 32'sd1;
		end else begin
			dout = shifted[31:0];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/jacobi_pressure_projection.sv
// A write item is stored when accepted, and a new item may follow in the next cycle.
// Read items return the word on result for one cycle, in the cycle after acceptance.
// A run visits cells one at a time through a single accumulator fed by one read per cycle:
// each cell update reads its n operands, accumulates the last one, then writes the result
// (4 operands for divergence, 5 per Jacobi sweep, 0 or 1 per edge, 4 per projected component).
// After reset a clearing pass over all 16384 cells zeroes velocity and pressure; busy is high meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jacobi_pressure_projection (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire jpp_pkg::item_t  item,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata,
	output logic                 result_valid,
	output jpp_pkg::res_t        result
);

	localparam int IW = jpp_pkg::IDX_W;
	localparam int XW = jpp_pkg::XW;
	localparam int YW = jpp_pkg::YW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0]    state_q;
	logic [2:0]    phase_q;
	logic [2:0]    step_q;
	logic          sub_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] clr_q;
	logic [7:0]    iters_q;
	logic [7:0]    it_q;
	logic          final_q;
	logic          ecnt_q;
	logic          psel_q;
	logic          pend_q;
	logic          neg_s1;
	logic [2:0]    msel_s1;
	logic          rv_q;
	logic          rk_q;
	logic          rz_q;

	logic accept;
	logic in_range;
	logic running;
	logic clearing;
	logic side;
	logic issue;
	logic wr_seq;
	logic last_sub;
	logic tdone;
	logic finish;
	logic ntog;
	logic nfinal;
	logic necnt;
	logic [7:0]    nit;
	logic [2:0]    nph;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [IW-1:0] nidx;
	logic [IW-1:0] seq_addr;
	logic [IW-1:0] item_addr;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic [2:0]    dst_p;
	logic [2:0]    rd_p;
	jpp_pkg::plan_t    plan;
	jpp_pkg::term_t    term;
	jpp_pkg::alu_ctl_t alu_ctl;
	logic signed [31:0] alu_out;
	logic signed [31:0] seq_din;
	logic [31:0] u_rd, v_rd, a_rd, b_rd, d_rd;
	logic [31:0] u_wd, v_wd, p_wd;
	logic u_we, v_we, a_we, b_we, d_we;
	logic item_wr;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign running   = (state_q == ST_RUN);
	assign clearing  = (state_q == ST_CLEAR);
	assign item_addr = IW'(item.cell_index);
	assign in_range  = (32'(item.cell_index) < 32'(jpp_pkg::CELL_COUNT));
	assign item_wr   = accept && (item.action == jpp_pkg::ACT_WRITE) && in_range;

	// Decode of the current operand and write step.
	always_comb begin
		plan = jpp_pkg::plan_f(phase_q, sub_q);
		side = (phase_q == jpp_pkg::PH_PEC || phase_q == jpp_pkg::PH_VEC) ?
		       (x_q == '0) : (y_q == '0);
		term = jpp_pkg::term_f(phase_q, sub_q, side, step_q);
		issue  = running && (step_q < plan.n);
		wr_seq = running && (step_q == plan.n + 3'd1);
		last_sub = !(phase_q == jpp_pkg::PH_PROJ || phase_q == jpp_pkg::PH_VEC ||
		             phase_q == jpp_pkg::PH_VER) || sub_q;
		case (term.off)
			jpp_pkg::OF_P1: seq_addr = idx_q + IW'(1);
			jpp_pkg::OF_M1: seq_addr = idx_q - IW'(1);
			jpp_pkg::OF_PW: seq_addr = idx_q + IW'(jpp_pkg::GRID_W);
			jpp_pkg::OF_MW: seq_addr = idx_q - IW'(jpp_pkg::GRID_W);
			default:        seq_addr = idx_q;
		endcase
		dst_p = jpp_pkg::phys_f(plan.dst, psel_q);
		rd_p  = jpp_pkg::phys_f(term.mem, psel_q);
	end

	// Next target cell within the pass of the current phase.
	always_comb begin
		nx    = x_q;
		ny    = y_q;
		nidx  = idx_q;
		tdone = 1'b0;
		case (phase_q)
			jpp_pkg::PH_PEC, jpp_pkg::PH_VEC: begin
				if (x_q == '0) begin
					nx   = XW'(jpp_pkg::GRID_W - 1);
					nidx = idx_q + IW'(jpp_pkg::GRID_W - 1);
				end else if (y_q < YW'(jpp_pkg::GRID_H - 1)) begin
					nx   = '0;
					ny   = y_q + YW'(1);
					nidx = idx_q + IW'(1);
				end else begin
					tdone = 1'b1;
				end
			end
			jpp_pkg::PH_PER, jpp_pkg::PH_VER: begin
				if (y_q == '0) begin
					ny   = YW'(jpp_pkg::GRID_H - 1);
					nidx = idx_q + IW'((jpp_pkg::GRID_H - 1) * jpp_pkg::GRID_W);
				end else if (x_q < XW'(jpp_pkg::GRID_W - 1)) begin
					ny   = '0;
					nx   = x_q + XW'(1);
					nidx = idx_q - IW'((jpp_pkg::GRID_H - 1) * jpp_pkg::GRID_W) + IW'(1);
				end else begin
					tdone = 1'b1;
				end
			end
			default: begin
				if (x_q < XW'(jpp_pkg::GRID_W - 2)) begin
					nx   = x_q + XW'(1);
					nidx = idx_q + IW'(1);
				end else if (y_q < YW'(jpp_pkg::GRID_H - 2)) begin
					nx   = XW'(1);
					ny   = y_q + YW'(1);
					nidx = idx_q + IW'(3);
				end else begin
					tdone = 1'b1;
				end
			end
		endcase
	end

	// Phase order of a run, buffer swaps and the sweep count.
	always_comb begin
		nph    = phase_q;
		ntog   = 1'b0;
		nfinal = final_q;
		necnt  = ecnt_q;
		nit    = it_q;
		finish = 1'b0;
		case (phase_q)
			jpp_pkg::PH_DIV: begin
				if (iters_q == 8'd0) begin
					ntog   = 1'b1;
					nfinal = 1'b1;
					necnt  = 1'b0;
					nph    = jpp_pkg::PH_PEC;
				end else begin
					nph = jpp_pkg::PH_JAC;
				end
			end
			jpp_pkg::PH_JAC: nph = jpp_pkg::PH_PEC;
			jpp_pkg::PH_PEC: nph = jpp_pkg::PH_PER;
			jpp_pkg::PH_PER: begin
				if (!final_q) begin
					if (8'(it_q + 8'd1) == iters_q) begin
						// Last sweep: no buffer swap; the edge passes follow.
						nfinal = 1'b1;
						necnt  = 1'b0;
						nph    = jpp_pkg::PH_PEC;
					end else begin
						ntog = 1'b1;
						nit  = 8'(it_q + 8'd1);
						nph  = jpp_pkg::PH_JAC;
					end
				end else if (!ecnt_q) begin
					necnt = 1'b1;
					nph   = jpp_pkg::PH_PEC;
				end else begin
					nph = jpp_pkg::PH_PROJ;
				end
			end
			jpp_pkg::PH_PROJ: nph = jpp_pkg::PH_VEC;
			jpp_pkg::PH_VEC:  nph = jpp_pkg::PH_VER;
			default:          finish = 1'b1;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= jpp_pkg::PH_DIV;
			step_q  <= '0;
			sub_q   <= 1'b0;
			x_q     <= '0;
			y_q     <= '0;
			idx_q   <= '0;
			clr_q   <= '0;
			it_q    <= '0;
			final_q <= 1'b0;
			ecnt_q  <= 1'b0;
			psel_q  <= 1'b0;
			pend_q  <= 1'b0;
			neg_s1  <= 1'b0;
			msel_s1 <= '0;
			rv_q    <= 1'b0;
			rk_q    <= 1'b0;
			rz_q    <= 1'b0;
		end else begin
			pend_q  <= issue;
			neg_s1  <= term.neg;
			msel_s1 <= rd_p;
			rv_q    <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(jpp_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && item.action == jpp_pkg::ACT_READ) begin
						rv_q <= 1'b1;
						rk_q <= 1'b0;
						rz_q <= !in_range;
					end
					if (accept && item.action == jpp_pkg::ACT_RUN) begin
						state_q <= ST_RUN;
						phase_q <= jpp_pkg::PH_DIV;
						step_q  <= '0;
						sub_q   <= 1'b0;
						x_q     <= XW'(1);
						y_q     <= YW'(1);
						idx_q   <= IW'(jpp_pkg::GRID_W + 1);
						it_q    <= '0;
						final_q <= 1'b0;
						ecnt_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (wr_seq) begin
						step_q <= '0;
						if (!last_sub) begin
							sub_q <= 1'b1;
						end else begin
							sub_q <= 1'b0;
							if (!tdone) begin
								x_q   <= nx;
								y_q   <= ny;
								idx_q <= nidx;
							end else begin
								phase_q <= nph;
								psel_q  <= psel_q ^ ntog;
								final_q <= nfinal;
								ecnt_q  <= necnt;
								it_q    <= nit;
								if (nph == jpp_pkg::PH_JAC || nph == jpp_pkg::PH_PROJ) begin
									x_q   <= XW'(1);
									y_q   <= YW'(1);
									idx_q <= IW'(jpp_pkg::GRID_W + 1);
								end else begin
									x_q   <= '0;
									y_q   <= '0;
									idx_q <= '0;
								end
								if (finish) begin
									state_q <= ST_IDLE;
									rv_q    <= 1'b1;
									rk_q    <= 1'b1;
									rz_q    <= 1'b1;
								end
							end
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Shared accumulator, held at zero outside a run.
	always_comb begin
		case (msel_s1)
			jpp_pkg::R_U: seq_din = u_rd;
			jpp_pkg::R_V: seq_din = v_rd;
			jpp_pkg::R_A: seq_din = a_rd;
			jpp_pkg::R_B: seq_din = b_rd;
			default:      seq_din = d_rd;
		endcase
		alu_ctl = '{clr: wr_seq || !running, acc_en: pend_q, neg: neg_s1, sh: plan.sh};
	end

	jpp_alu u_alu (
		.clk  (clk),
		.ctl  (alu_ctl),
		.din  (seq_din),
		.dout (alu_out)
	);

	// Store ports: clearing pass, item writes and sequencer writes.
	always_comb begin
		raddr = running ? seq_addr : item_addr;
		waddr = clearing ? clr_q : (running ? idx_q : item_addr);
		u_we  = clearing || item_wr || (wr_seq && dst_p == jpp_pkg::R_U);
		v_we  = clearing || item_wr || (wr_seq && dst_p == jpp_pkg::R_V);
		a_we  = clearing || (wr_seq && dst_p == jpp_pkg::R_A);
		b_we  = clearing || (wr_seq && dst_p == jpp_pkg::R_B);
		d_we  = wr_seq && dst_p == jpp_pkg::R_D;
		u_wd  = clearing ? 32'd0 : (running ? alu_out : item.u_in);
		v_wd  = clearing ? 32'd0 : (running ? alu_out : item.v_in);
		p_wd  = clearing ? 32'd0 : alu_out;
	end

	jpp_ram #(.WIDTH(32), .DEPTH(jpp_pkg::CELL_COUNT)) u_ram_u (
		.clk(clk), .we(u_we), .waddr(waddr), .wdata(u_wd), .raddr(raddr), .rdata(u_rd));
	jpp_ram #(.WIDTH(32), .DEPTH(jpp_pkg::CELL_COUNT)) u_ram_v (
		.clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wd), .raddr(raddr), .rdata(v_rd));
	jpp_ram #(.WIDTH(32), .DEPTH(jpp_pkg::CELL_COUNT)) u_ram_a (
		.clk(clk), .we(a_we), .waddr(waddr), .wdata(p_wd), .raddr(raddr), .rdata(a_rd));
	jpp_ram #(.WIDTH(32), .DEPTH(jpp_pkg::CELL_COUNT)) u_ram_b (
		.clk(clk), .we(b_we), .waddr(waddr), .wdata(p_wd), .raddr(raddr), .rdata(b_rd));
	jpp_ram #(.WIDTH(32), .DEPTH(jpp_pkg::CELL_COUNT)) u_ram_d (
		.clk(clk), .we(d_we), .waddr(waddr), .wdata(alu_out), .raddr(raddr), .rdata(d_rd));

	// Iteration count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iters_q <= jpp_pkg::ITER_RESET;
		end else if (cfg_we) begin
			iters_q <= cfg_wdata;
		end
	end

	// Result word.
	assign result_valid       = rv_q;
	assign result.result_kind = rk_q;
	assign result.u_out       = rz_q ? 32'sd0 : u_rd;
	assign result.v_out       = rz_q ? 32'sd0 : v_rd;

	`JPP_ASSERT(a_step_bound, clk, arst_n, running |-> (step_q <= plan.n + 3'd1), "step past write")
	`JPP_ASSERT(a_psel_run, clk, arst_n, !running |=> $stable(psel_q), "pressure select moved idle")
	`JPP_ASSERT(a_done_run, clk, arst_n, (rv_q && rk_q) |-> $past(running), "run word without run")
	`JPP_ASSERT_ALWAYS(a_pend_run, clk, pend_q |-> running, "operand pending outside a run")

endmodule
`default_nettype wire
